>>> rtl/bcc_pkg.sv
// Shared types and constants for the box and circle collision pair block.
// Used by bcc_pair_test and box_circle_collision_pairs; depends on nothing.
`default_nettype none

package bcc_pkg;

  localparam int ID_W    = 16;
  localparam int POS_W   = 24;
  localparam int ELEV_W  = 16;
  localparam int SIZE_W  = 16;
  localparam int EPSL_W  = 8;
  localparam int EPSQ_W  = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam int EPSL_RESET = 3;
  localparam int EPSQ_RESET = 655;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EPS_LINEAR  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS_SQUARED = 8'd1;

  // One entity as it is held in the store and in the current-item register.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [ELEV_W-1:0] elev;
    logic              has_box;
    logic              has_circle;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [SIZE_W-1:0] radius;
  } entity_t;

  // Result of one pair test leaving the test pipeline.
  typedef struct packed {
    logic            valid;
    logic            hit;
    logic [ID_W-1:0] id;
  } pair_res_t;

endpackage

`default_nettype wire

>>> rtl/bcc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bcc_pair_test.sv
// Three-stage pipeline that tests one stored entity against the current one.
// Depends on bcc_pkg for entity_t and pair_res_t.
`default_nettype none

module bcc_pair_test (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire bcc_pkg::entity_t           stored_i,
  input  wire bcc_pkg::entity_t           cur_i,
  input  wire logic [bcc_pkg::EPSL_W-1:0] eps_linear_i,
  input  wire logic [bcc_pkg::EPSQ_W-1:0] eps_squared_i,
  output bcc_pkg::pair_res_t              res_o,
  output logic                            busy_o
);

  localparam int AW = 27;  // wide enough for position plus size plus tolerance
  localparam int DW = 26;  // clamped distance per axis
  localparam int PW = 2 * DW;

  function automatic logic signed [AW-1:0] ext_pos(input logic [bcc_pkg::POS_W-1:0] v);
    logic signed [bcc_pkg::POS_W-1:0] s;
    s = $signed(v);
    return AW'(s);
  endfunction

  function automatic logic signed [AW-1:0] ext_u(input logic [bcc_pkg::SIZE_W-1:0] v);
    return $signed({{(AW - bcc_pkg::SIZE_W){1'b0}}, v});
  endfunction

  // Distance from point c to the interval [lo, lo+len] (zero inside).
  function automatic logic signed [DW-1:0] clamp_dist(input logic signed [AW-1:0] c,
                                                      input logic signed [AW-1:0] lo,
                                                      input logic signed [AW-1:0] len);
    logic signed [AW-1:0] below;
    logic signed [AW-1:0] above;
    logic signed [AW-1:0] r;
    below = c - lo;
    above = c - lo - len;
    if (below < 0) begin
      r = below;
    end else if (above > 0) begin
      r = above;
    end else begin
      r = '0;
    end
    return r[DW-1:0];
  endfunction

  // Stage A: compares, clamps and differences.
  logic signed [AW-1:0] px, py, sx, sy, w, h, sw, sh, e;
  logic                 bb_x, bb_y, gate;
  logic [bcc_pkg::ELEV_W:0]   de;
  logic [bcc_pkg::ELEV_W-1:0] de_abs;
  logic signed [AW-1:0] dxc_w, dyc_w;

  logic                        a_v_q, a_bb_q, a_bc1_q, a_bc2_q, a_cc_q;
  logic [bcc_pkg::ID_W-1:0]    a_id_q;
  logic signed [DW-1:0]        a_dx1_q, a_dy1_q, a_dx2_q, a_dy2_q, a_dxc_q, a_dyc_q;
  logic [bcc_pkg::SIZE_W-1:0]  a_r_q, a_sr_q;
  logic [bcc_pkg::SIZE_W:0]    a_rs_q;

  always_comb begin
    px = ext_pos(cur_i.x);
    py = ext_pos(cur_i.y);
    sx = ext_pos(stored_i.x);
    sy = ext_pos(stored_i.y);
    w  = ext_u(cur_i.width);
    h  = ext_u(cur_i.height);
    sw = ext_u(stored_i.width);
    sh = ext_u(stored_i.height);
    e  = ext_u({{(bcc_pkg::SIZE_W - bcc_pkg::EPSL_W){1'b0}}, eps_linear_i});
    bb_x = (sx + sw > px - e) && (sx < px + w + e);
    bb_y = (sy + sh > py - e) && (sy < py + h + e);
    de = {1'b0, cur_i.elev} - {1'b0, stored_i.elev};
    de_abs = de[bcc_pkg::ELEV_W] ? bcc_pkg::ELEV_W'(-de) : de[bcc_pkg::ELEV_W-1:0];
    gate = (stored_i.id != cur_i.id) &&
           (de_abs < {{(bcc_pkg::ELEV_W - bcc_pkg::EPSL_W){1'b0}}, eps_linear_i});
    dxc_w = px - sx;
    dyc_w = py - sy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_id_q  <= stored_i.id;
    a_bb_q  <= gate && stored_i.has_box && cur_i.has_box && bb_x && bb_y;
    a_bc1_q <= gate && stored_i.has_box && cur_i.has_circle;
    a_bc2_q <= gate && stored_i.has_circle && cur_i.has_box;
    a_cc_q  <= gate && stored_i.has_circle && cur_i.has_circle;
    // Stored box against the new circle, then new box against the stored circle.
    a_dx1_q <= clamp_dist(px, sx, sw);
    a_dy1_q <= clamp_dist(py, sy, sh);
    a_dx2_q <= clamp_dist(sx, px, w);
    a_dy2_q <= clamp_dist(sy, py, h);
    a_dxc_q <= dxc_w[DW-1:0];
    a_dyc_q <= dyc_w[DW-1:0];
    a_r_q   <= cur_i.radius;
    a_sr_q  <= stored_i.radius;
    a_rs_q  <= {1'b0, cur_i.radius} + {1'b0, stored_i.radius};
  end

  // Stage B: squares.
  logic signed [PW-1:0] sq_x1, sq_y1, sq_x2, sq_y2, sq_xc, sq_yc;
  logic                 b_v_q, b_bb_q, b_bc1_q, b_bc2_q, b_cc_q;
  logic [bcc_pkg::ID_W-1:0] b_id_q;
  logic signed [PW-1:0] b_x1_q, b_y1_q, b_x2_q, b_y2_q, b_xc_q, b_yc_q;
  logic [2*bcc_pkg::SIZE_W-1:0]   b_r2_q, b_sr2_q;
  logic [2*bcc_pkg::SIZE_W+1:0]   b_rs2_q;

  always_comb begin
    sq_x1 = a_dx1_q * a_dx1_q;
    sq_y1 = a_dy1_q * a_dy1_q;
    sq_x2 = a_dx2_q * a_dx2_q;
    sq_y2 = a_dy2_q * a_dy2_q;
    sq_xc = a_dxc_q * a_dxc_q;
    sq_yc = a_dyc_q * a_dyc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_id_q  <= a_id_q;
    b_bb_q  <= a_bb_q;
    b_bc1_q <= a_bc1_q;
    b_bc2_q <= a_bc2_q;
    b_cc_q  <= a_cc_q;
    b_x1_q  <= sq_x1;
    b_y1_q  <= sq_y1;
    b_x2_q  <= sq_x2;
    b_y2_q  <= sq_y2;
    b_xc_q  <= sq_xc;
    b_yc_q  <= sq_yc;
    b_r2_q  <= a_r_q * a_r_q;
    b_sr2_q <= a_sr_q * a_sr_q;
    b_rs2_q <= a_rs_q * a_rs_q;
  end

  // Stage C: sums and final compares.
  logic signed [PW:0] d1, d2, dc, r2, sr2, lim_cc;
  logic               hit;
  logic                     res_v_q, res_hit_q;
  logic [bcc_pkg::ID_W-1:0] res_id_q;

  always_comb begin
    d1 = (PW+1)'(b_x1_q) + (PW+1)'(b_y1_q);
    d2 = (PW+1)'(b_x2_q) + (PW+1)'(b_y2_q);
    dc = (PW+1)'(b_xc_q) + (PW+1)'(b_yc_q);
    r2  = $signed({{(PW + 1 - 2*bcc_pkg::SIZE_W){1'b0}}, b_r2_q});
    sr2 = $signed({{(PW + 1 - 2*bcc_pkg::SIZE_W){1'b0}}, b_sr2_q});
    lim_cc = $signed({{(PW - 1 - 2*bcc_pkg::SIZE_W){1'b0}}, b_rs2_q}) +
             $signed({{(PW + 1 - bcc_pkg::EPSQ_W){1'b0}}, eps_squared_i});
    hit = b_bb_q ||
          (b_bc1_q && (d1 < r2)) ||
          (b_bc2_q && (d2 < sr2)) ||
          (b_cc_q && (dc < lim_cc));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_hit_q <= hit;
    res_id_q  <= b_id_q;
  end

  assign res_o  = {res_v_q, res_hit_q, res_id_q};
  assign busy_o = a_v_q || b_v_q || res_v_q;

endmodule

`default_nettype wire

>>> rtl/box_circle_collision_pairs.sv
// Top level of the box and circle collision pair block: sequencer, entity store,
// pair-test pipeline and result register. Depends on bcc_pkg, bcc_ram, bcc_pair_test.
//
//   Channel  | Signals                                          | Direction
//   ---------+--------------------------------------------------+----------
//   command  | start, busy, start_frame_i .. radius_i           | in (busy out)
//   config   | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i| in (ready out)
//   result   | result_valid_o, earlier_id_o, newer_id_o,        | out
//            | last_pair_o                                      |
//
// An entity is taken when start is high and busy is low. The block then reads
// the stored entities of the frame (at most MAX_ENTITIES) from the store memory
// one per cycle through the test pipeline; when the frame holds no entity yet
// it goes straight to waiting for the pipeline to drain. The single read port
// of the store sets that rate.
// Each colliding pair leaves as one word with a one-cycle strobe on
// result_valid_o; the receiver cannot stall. Reset clears the control state
// and the store count; the store memory itself needs no clearing because only
// entries below the count are read.
`default_nettype none

module box_circle_collision_pairs #(
  parameter int MAX_ENTITIES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Command channel.
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          start_frame_i,
  input  wire logic [bcc_pkg::ID_W-1:0]      entity_id_i,
  input  wire logic signed [bcc_pkg::POS_W-1:0] pos_x_i,
  input  wire logic signed [bcc_pkg::POS_W-1:0] pos_y_i,
  input  wire logic [bcc_pkg::ELEV_W-1:0]    elevation_i,
  input  wire logic                          has_box_i,
  input  wire logic                          has_circle_i,
  input  wire logic [bcc_pkg::SIZE_W-1:0]    box_width_i,
  input  wire logic [bcc_pkg::SIZE_W-1:0]    box_height_i,
  input  wire logic [bcc_pkg::SIZE_W-1:0]    radius_i,
  // Configuration channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bcc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // Result channel.
  output logic                               result_valid_o,
  output logic [bcc_pkg::ID_W-1:0]           earlier_id_o,
  output logic [bcc_pkg::ID_W-1:0]           newer_id_o,
  output logic                               last_pair_o
);

  localparam int IDX_W = $clog2(MAX_ENTITIES);
  localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTITIES);
  localparam logic [CNT_W-1:0] RES_CAP = CNT_W'(MAX_ENTITIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  // Configuration registers. Writes are taken only while no entity is in
  // flight, so the tolerances stay fixed for the whole scan of an entity.
  logic [bcc_pkg::EPSL_W-1:0] eps_linear_q;
  logic [bcc_pkg::EPSQ_W-1:0] eps_squared_q;

  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_linear_q  <= bcc_pkg::EPSL_W'(bcc_pkg::EPSL_RESET);
      eps_squared_q <= bcc_pkg::EPSQ_W'(bcc_pkg::EPSQ_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bcc_pkg::REG_EPS_LINEAR:  eps_linear_q  <= cfg_data_i[bcc_pkg::EPSL_W-1:0];
        bcc_pkg::REG_EPS_SQUARED: eps_squared_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_e              state_q;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    idx_q;
  logic [CNT_W-1:0]    res_cnt_q;
  logic                rd_v_q;
  logic                pend_v_q;
  logic [bcc_pkg::ID_W-1:0] pend_id_q;
  bcc_pkg::entity_t    cur_q;

  // Results.
  logic                     out_v_q, out_last_q;
  logic [bcc_pkg::ID_W-1:0] out_earlier_q, out_newer_q;

  bcc_pkg::entity_t   in_ent;
  bcc_pkg::entity_t   rd_ent;
  bcc_pkg::pair_res_t pt_res;
  logic               pt_busy;
  logic               accept, issue, last_issue, finish, take_hit, store_wr;
  logic [CNT_W-1:0]   base_cnt;

  always_comb begin
    in_ent.id         = entity_id_i;
    in_ent.x          = pos_x_i;
    in_ent.y          = pos_y_i;
    in_ent.elev       = elevation_i;
    in_ent.has_box    = has_box_i;
    in_ent.has_circle = has_circle_i;
    in_ent.width      = box_width_i;
    in_ent.height     = box_height_i;
    in_ent.radius     = radius_i;
  end

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign base_cnt   = start_frame_i ? '0 : count_q;
  assign issue      = (state_q == ST_SCAN);
  assign last_issue = issue && (CNT_W'(idx_q) == count_q - CNT_W'(1));
  // The entity is done once the last test has left the pipeline.
  assign finish     = (state_q == ST_DRAIN) && !rd_v_q && !pt_busy;
  assign take_hit   = pt_res.valid && pt_res.hit && (res_cnt_q < RES_CAP);
  assign store_wr   = finish && (count_q < MAX_CNT);

  bcc_ram #(
    .WIDTH ($bits(bcc_pkg::entity_t)),
    .DEPTH (MAX_ENTITIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_wr),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (cur_q),
    .re_i    (issue),
    .raddr_i (idx_q),
    .rdata_o (rd_ent)
  );

  bcc_pair_test u_test (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (rd_v_q),
    .stored_i      (rd_ent),
    .cur_i         (cur_q),
    .eps_linear_i  (eps_linear_q),
    .eps_squared_i (eps_squared_q),
    .res_o         (pt_res),
    .busy_o        (pt_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      res_cnt_q <= '0;
      rd_v_q    <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      rd_v_q  <= issue;
      // A new hit pushes out the held one, which then cannot be the last; at
      // the end of the entity the held pair leaves as the last one.
      out_v_q <= pend_v_q && (take_hit || finish);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            count_q   <= base_cnt;
            idx_q     <= '0;
            res_cnt_q <= '0;
            pend_v_q  <= 1'b0;
            state_q   <= (base_cnt == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx_q <= idx_q + IDX_W'(1);
          if (last_issue) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            if (store_wr) begin
              count_q <= count_q + CNT_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (take_hit) begin
        pend_v_q  <= 1'b1;
        res_cnt_q <= res_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= in_ent;
    end
    if (take_hit) begin
      pend_id_q <= pt_res.id;
    end
    out_earlier_q <= pend_id_q;
    out_newer_q   <= cur_q.id;
    out_last_q    <= finish;
  end

  assign result_valid_o = out_v_q;
  assign earlier_id_o   = out_earlier_q;
  assign newer_id_o     = out_newer_q;
  assign last_pair_o    = out_last_q;

endmodule

`default_nettype wire
